@@ design/las_pkg.sv @@
package las_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned SCORE_W = 12;
  localparam int unsigned PEN_W   = 4;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_W   = 2;
  // Signed working width for a cell sum: one sign bit plus one carry bit.
  localparam int unsigned SUM_W   = SCORE_W + 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [PEN_W-1:0]   PEN_RESET = PEN_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_REF   = 2'd0,
    OP_QUERY = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_MATCH    = 2'd0,
    CFG_MISMATCH = 2'd1,
    CFG_GAP      = 2'd2
  } cfg_e;

  // Wavefront item handed from one cell to the next.
  typedef struct packed {
    logic               valid;
    logic [SYM_W-1:0]   sym;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] best;
  } pkt_t;

  typedef struct packed {
    logic [PEN_W-1:0] match_score;
    logic [PEN_W-1:0] mismatch_penalty;
    logic [PEN_W-1:0] gap_penalty;
  } score_cfg_t;

endpackage

@@ design/las_cell.sv @@
module las_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  las_pkg::pkt_t                 pkt_i,
  input  las_pkg::score_cfg_t           cfg_i,
  input  logic                          load_i,
  input  logic [las_pkg::SYM_W-1:0]     load_sym_i,
  input  logic                          clear_i,
  output las_pkg::pkt_t                 pkt_o
);

  logic                            active_q, active_d;
  logic [las_pkg::SYM_W-1:0]       sym_q, sym_d;
  logic [las_pkg::SCORE_W-1:0]     h_q, h_d;
  logic                            valid_q, valid_d;
  logic [las_pkg::SYM_W-1:0]       osym_q, osym_d;
  logic [las_pkg::SCORE_W-1:0]     odiag_q, odiag_d;
  logic [las_pkg::SCORE_W-1:0]     oleft_q, oleft_d;
  logic [las_pkg::SCORE_W-1:0]     obest_q, obest_d;

  logic signed [las_pkg::SUM_W-1:0] diag_s, up_s, left_s, sd_s, gp_s, cand_s, v_s;
  logic [las_pkg::SCORE_W-1:0]      v;

  always_comb begin
    diag_s = $signed({2'b00, pkt_i.diag});
    up_s   = $signed({2'b00, h_q});
    left_s = $signed({2'b00, pkt_i.left});
    gp_s   = $signed({{(las_pkg::SUM_W-las_pkg::PEN_W){1'b0}}, cfg_i.gap_penalty});
    if (pkt_i.sym == sym_q) begin
      sd_s = diag_s + $signed({{(las_pkg::SUM_W-las_pkg::PEN_W){1'b0}}, cfg_i.match_score});
    end else begin
      sd_s = diag_s - $signed({{(las_pkg::SUM_W-las_pkg::PEN_W){1'b0}},
                               cfg_i.mismatch_penalty});
    end
    cand_s = ((up_s - gp_s) > (left_s - gp_s)) ? (up_s - gp_s) : (left_s - gp_s);
    v_s    = (sd_s > cand_s) ? sd_s : cand_s;
    if (v_s < 0) begin
      v = '0;
    end else if (v_s > $signed({2'b00, las_pkg::SCORE_MAX})) begin
      v = las_pkg::SCORE_MAX;
    end else begin
      v = v_s[las_pkg::SCORE_W-1:0];
    end
  end

  always_comb begin
    active_d = active_q;
    sym_d    = sym_q;
    h_d      = h_q;
    valid_d  = pkt_i.valid;
    osym_d   = pkt_i.sym;
    odiag_d  = pkt_i.diag;
    oleft_d  = pkt_i.left;
    obest_d  = pkt_i.best;
    if (clear_i) begin
      active_d = 1'b0;
      h_d      = '0;
    end else if (load_i) begin
      active_d = 1'b1;
      sym_d    = load_sym_i;
      h_d      = '0;
    end else if (pkt_i.valid && active_q) begin
      // The old row score becomes the diagonal of the next column.
      h_d     = v;
      odiag_d = h_q;
      oleft_d = v;
      obest_d = (v > pkt_i.best) ? v : pkt_i.best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      h_q      <= '0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      h_q      <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q   <= sym_d;
    osym_q  <= osym_d;
    odiag_q <= odiag_d;
    oleft_q <= oleft_d;
    obest_q <= obest_d;
  end

  assign pkt_o = '{valid: valid_q, sym: osym_q, diag: odiag_q, left: oleft_q, best: obest_q};

endmodule

@@ design/local_alignment_score.sv @@
// Smith-Waterman local alignment score with a linear gap penalty, built as a
// row of MAX_REF_LEN cells, one per reference column. Reference items load the
// next free cell; query items enter the first cell and move one cell per clock,
// so a query item is accepted in every cycle and its row is finished when it
// leaves the last cell, where its best score is folded into the pair
// maximum. Reference and end-of-pair items wait until every query in the row
// has left the last cell; an end-of-pair item also waits for the output
// register to be free, then clears the pair.
module local_alignment_score #(
  parameter int unsigned MAX_REF_LEN = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [las_pkg::CFG_W-1:0]   cfg_addr_i,
  input  logic [las_pkg::PEN_W-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] symbol
  input  logic [1:0]                  s_axis_tuser,   // [1:0] opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata    // [11:0] best_score, [12] ref_overflow
);

  localparam int unsigned LEN_W = $clog2(MAX_REF_LEN + 1);
  localparam int unsigned CNT_W = $clog2(MAX_REF_LEN + 2);

  las_pkg::score_cfg_t         cfg_q;
  logic [LEN_W-1:0]            len_q, len_d;
  logic [CNT_W-1:0]            inflight_q, inflight_d;
  logic [las_pkg::SCORE_W-1:0] best_q, best_d;
  logic                        ovf_q, ovf_d;
  logic                        out_valid_q, out_valid_d;
  logic [las_pkg::SCORE_W-1:0] out_best_q;
  logic                        out_ovf_q;

  las_pkg::op_e   op;
  logic           idle, in_acc, acc_ref, acc_query, acc_end, clear;
  las_pkg::pkt_t  pkt [MAX_REF_LEN+1];

  assign op   = las_pkg::op_e'(s_axis_tuser);
  assign idle = (inflight_q == '0);

  always_comb begin
    case (op)
      las_pkg::OP_QUERY: s_axis_tready = 1'b1;
      las_pkg::OP_REF:   s_axis_tready = idle;
      las_pkg::OP_END:   s_axis_tready = idle && (!out_valid_q || m_axis_tready);
      default:           s_axis_tready = 1'b1;
    endcase
  end

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign acc_ref   = in_acc && (op == las_pkg::OP_REF);
  assign acc_query = in_acc && (op == las_pkg::OP_QUERY);
  assign acc_end   = in_acc && (op == las_pkg::OP_END);
  assign clear     = acc_end;

  assign pkt[0] = '{valid: acc_query, sym: s_axis_tdata, diag: '0, left: '0, best: '0};

  for (genvar k = 0; k < MAX_REF_LEN; k++) begin : g_cell
    las_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pkt_i      (pkt[k]),
      .cfg_i      (cfg_q),
      .load_i     (acc_ref && (len_q == LEN_W'(k))),
      .load_sym_i (s_axis_tdata),
      .clear_i    (clear),
      .pkt_o      (pkt[k+1])
    );
  end

  always_comb begin
    len_d       = len_q;
    inflight_d  = inflight_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    if (pkt[MAX_REF_LEN].valid && (pkt[MAX_REF_LEN].best > best_q)) begin
      best_d = pkt[MAX_REF_LEN].best;
    end
    if (acc_query && !pkt[MAX_REF_LEN].valid) begin
      inflight_d = inflight_q + CNT_W'(1);
    end else if (!acc_query && pkt[MAX_REF_LEN].valid) begin
      inflight_d = inflight_q - CNT_W'(1);
    end
    if (acc_ref) begin
      if (len_q == LEN_W'(MAX_REF_LEN)) begin
        ovf_d = 1'b1;
      end else begin
        len_d = len_q + LEN_W'(1);
      end
    end
    if (acc_end) begin
      out_valid_d = 1'b1;
      len_d       = '0;
      best_d      = '0;
      ovf_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{match_score: las_pkg::PEN_RESET,
                       mismatch_penalty: las_pkg::PEN_RESET,
                       gap_penalty: las_pkg::PEN_RESET};
      len_q       <= '0;
      inflight_q  <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (las_pkg::cfg_e'(cfg_addr_i))
          las_pkg::CFG_MATCH:    cfg_q.match_score      <= cfg_wdata_i;
          las_pkg::CFG_MISMATCH: cfg_q.mismatch_penalty <= cfg_wdata_i;
          las_pkg::CFG_GAP:      cfg_q.gap_penalty      <= cfg_wdata_i;
          default: ;
        endcase
      end
      len_q       <= len_d;
      inflight_q  <= inflight_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_end) begin
      out_best_q <= best_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_ovf_q, out_best_q};

  a_ref_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_ref || acc_end) |-> (inflight_q == '0))
    else $error("reference or end item taken while queries are in the row");

  a_exit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt[MAX_REF_LEN].valid |-> (inflight_q != '0))
    else $error("query left the row without being counted");

  a_inflight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(MAX_REF_LEN))
    else $error("more queries in flight than cells");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_end |=> ((len_q == '0) && !ovf_q && m_axis_tvalid))
    else $error("end item did not clear the pair or raise a result");

endmodule
